>>> rtl/b64e_pkg.sv
package b64e_pkg;

	localparam int FifoDepth = 4;
	localparam int FifoAw = $clog2(FifoDepth);

	localparam logic [1:0] PHASE_0 = 2'd0;
	localparam logic [1:0] PHASE_1 = 2'd1;
	localparam logic [1:0] PHASE_2 = 2'd2;

	localparam logic [7:0] PAD_CHAR = 8'h3d;

	// one accepted byte, as the characters it produces
	typedef struct packed {
		logic [5:0] sx0;
		logic [5:0] sx1;
		logic [1:0] cnt_m1; // characters minus one; index 2 and 3 are pad
		logic       last;
	} b64e_entry_t;

	function automatic logic [7:0] b64e_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] ch;
		w = {2'b00, v};
		if (v < 6'd26)
			ch = w + 8'd65;
		else if (v < 6'd52)
			ch = w + 8'd71;
		else if (v < 6'd62)
			ch = w - 8'd4;
		else if (v == 6'd62)
			ch = 8'h2b;
		else
			ch = 8'h2f;
		return ch;
	endfunction

endpackage

>>> rtl/base64_stream_encoder_top.sv
// channel | signals                         | direction
// in      | in_valid, in_stall, data_byte,  | byte beats in
//         | end_of_message                  |
// out     | out_valid, out_stall, out_char, | character beats out
//         | last_char                       |
// A byte is taken and queued (4 entries) as the characters it makes.
// The output stage sends one character per cycle while the queue holds an entry and
// out_stall is low: 1 or 2 per middle byte, 2 to 4 on the last byte.
// arst_n clears phase, held bits, queue pointers and output valid.
// in_stall rises only when the queue is full; out_stall holds the output register.
module base64_stream_encoder_top
	import b64e_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_message,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_char
);

	b64e_entry_t push_data;
	b64e_entry_t head;
	logic        push;
	logic        pop;
	logic        empty;
	logic        full;

	b64e_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.fifo_full      (full),
		.push           (push),
		.push_data      (push_data)
	);

	b64e_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

>>> rtl/b64e_front.sv
module b64e_front
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	input  logic        fifo_full,
	output logic        push,
	output b64e_entry_t push_data
);

	logic [1:0] group_phase_q;
	logic [3:0] held_bits_q;
	logic [1:0] phase_d;
	logic [3:0] held_d;

	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full;

	always_comb begin
		push_data.last = end_of_message;
		unique case (group_phase_q)
			PHASE_1: begin
				push_data.sx0    = {held_bits_q[1:0], data_byte[7:4]};
				push_data.sx1    = {data_byte[3:0], 2'b00};
				push_data.cnt_m1 = end_of_message ? 2'd2 : 2'd0;
				phase_d          = PHASE_2;
				held_d           = data_byte[3:0];
			end
			PHASE_2: begin
				push_data.sx0    = {held_bits_q, data_byte[7:6]};
				push_data.sx1    = data_byte[5:0];
				push_data.cnt_m1 = 2'd1;
				phase_d          = PHASE_0;
				held_d           = 4'd0;
			end
			default: begin
				push_data.sx0    = data_byte[7:2];
				push_data.sx1    = {data_byte[1:0], 4'b0000};
				push_data.cnt_m1 = end_of_message ? 2'd3 : 2'd0;
				phase_d          = PHASE_1;
				held_d           = {2'b00, data_byte[1:0]};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_phase_q <= PHASE_0;
			held_bits_q   <= 4'd0;
		end else if (push) begin
			if (end_of_message) begin
				group_phase_q <= PHASE_0;
				held_bits_q   <= 4'd0;
			end else begin
				group_phase_q <= phase_d;
				held_bits_q   <= held_d;
			end
		end
	end

endmodule

>>> rtl/b64e_fifo.sv
module b64e_fifo
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  b64e_entry_t push_data,
	input  logic        pop,
	output b64e_entry_t head,
	output logic        empty,
	output logic        full
);

	b64e_entry_t          mem_q [FifoDepth];
	logic [FifoAw-1:0]    wr_ptr_q;
	logic [FifoAw-1:0]    rd_ptr_q;
	logic [FifoAw:0]      count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == FifoAw'(0) + (FifoAw+1)'(FifoDepth));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/b64e_back.sv
module b64e_back
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  b64e_entry_t head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_char,
	output logic        last_char
);

	logic [1:0] char_idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_char_q;
	logic       load;
	logic       final_idx;
	logic [7:0] char_d;

	assign load      = !empty && (!out_valid_q || !out_stall);
	assign final_idx = (char_idx_q == head.cnt_m1);
	assign pop       = load && final_idx;

	always_comb begin
		case (char_idx_q)
			2'd0:    char_d = b64e_char(head.sx0);
			2'd1:    char_d = b64e_char(head.sx1);
			default: char_d = PAD_CHAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_idx_q  <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				char_idx_q <= final_idx ? 2'd0 : char_idx_q + 2'd1;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q  <= char_d;
			last_char_q <= head.last && final_idx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_char_q;

endmodule
